/* sv/dnsd_pkg.sv */
// Shared constants, payload structs and controller/datapath command types.
`default_nettype none

package dnsd_pkg;

  // Packet store geometry and walk limits.
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int MAX_HOPS    = 5;
  localparam int HOP_W       = $clog2(MAX_HOPS + 1);
  localparam int CUR_W       = 14;
  localparam int LEN_W       = 11;

  // Input word modes.
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_PULL  = 2'd2;

  // End status codes on the final marker.
  localparam logic [1:0] END_TERM    = 2'd0;
  localparam logic [1:0] END_OVERRUN = 2'd1;
  localparam logic [1:0] END_HOPS    = 2'd2;

  // Label byte decoding.
  localparam logic [7:0] PTR_MARK      = 8'hC0;
  localparam logic [7:0] PTR_HIGH_MASK = 8'h3F;
  localparam logic [7:0] DOT_CHAR      = 8'h2E;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  load_address;
    logic [7:0]  load_byte;
    logic [9:0]  start_offset;
    logic [10:0] packet_length;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  name_char;
    logic        last;
    logic [10:0] end_offset;
    logic [1:0]  end_status;
  } out_word_t;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_READ_CUR,
    OP_FINISH,
    OP_PTR_FIRST,
    OP_PTR_JUMP,
    OP_TERM,
    OP_LABEL_OPEN,
    OP_CHAR,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] fin_status;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic finished;
    logic label_active;
    logic hop_limit;
    logic cur_past;
    logic is_ptr;
    logic ptr_past;
    logic is_zero;
    logic label_past;
    logic dot_needed;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* sv/dnsd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dnsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* sv/dnsd_datapath.sv */
// Decoder datapath: packet store, walk registers and the output word register.
`default_nettype none

module dnsd_datapath
  import dnsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cmd_t      cmd,
  input  wire in_word_t  in_word,
  input  wire logic      out_ready,
  output      sts_t      sts,
  output      logic      out_valid,
  output      out_word_t out_word
);

  logic [CUR_W-1:0] cursor_r;
  logic [7:0]       left_r;
  logic [LEN_W-1:0] limit_r;
  logic [LEN_W-1:0] stop_r;
  logic             ptr_r;
  logic [HOP_W-1:0] hop_r;
  logic             dot_r;
  logic             fin_r;
  logic [1:0]       status_r;
  logic [5:0]       hi_r;
  logic [7:0]       char_r;
  logic             out_valid_r;
  out_word_t        out_r;

  logic [CUR_W:0]   cur_ext;
  logic [CUR_W:0]   cur_p1;
  logic [CUR_W:0]   lim_ext;
  logic [7:0]       rd_data;
  logic [ADDR_W-1:0] rd_addr;

  // Cursor arithmetic, one bit wider than the cursor so nothing wraps.
  assign cur_ext = {1'b0, cursor_r};
  assign cur_p1  = cur_ext + (CUR_W + 1)'(1);
  assign lim_ext = (CUR_W + 1)'(limit_r);

  // Read at the cursor for a length byte or a character refill, else one past it.
  assign rd_addr = (cmd.op == OP_READ_CUR) ? cursor_r[ADDR_W-1:0] : cur_p1[ADDR_W-1:0];

  dnsd_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (cmd.op == OP_LOAD),
    .wr_addr(in_word.load_address[ADDR_W-1:0]),
    .wr_data(in_word.load_byte),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Status seen by the controller; the byte tests apply to the last length byte read.
  always_comb begin
    sts.finished     = fin_r;
    sts.label_active = (left_r != 8'd0);
    sts.hop_limit    = (hop_r >= HOP_W'(MAX_HOPS));
    sts.cur_past     = (cur_ext >= lim_ext);
    sts.is_ptr       = ((rd_data & PTR_MARK) == PTR_MARK);
    sts.ptr_past     = (cur_p1 >= lim_ext);
    sts.is_zero      = (rd_data == 8'd0);
    sts.label_past   = ((cur_p1 + (CUR_W + 1)'(rd_data)) > lim_ext);
    sts.dot_needed   = dot_r;
    sts.out_free     = !out_valid_r || out_ready;
  end

  // Walk state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      left_r   <= '0;
      limit_r  <= '0;
      stop_r   <= '0;
      ptr_r    <= 1'b0;
      hop_r    <= '0;
      dot_r    <= 1'b0;
      fin_r    <= 1'b1;
      status_r <= END_TERM;
    end else begin
      unique case (cmd.op)
        OP_START: begin
          cursor_r <= CUR_W'(in_word.start_offset);
          limit_r  <= (in_word.packet_length > LEN_W'(STORE_DEPTH)) ?
                      LEN_W'(STORE_DEPTH) : in_word.packet_length;
          stop_r   <= LEN_W'(in_word.start_offset);
          left_r   <= '0;
          ptr_r    <= 1'b0;
          hop_r    <= '0;
          dot_r    <= 1'b0;
          fin_r    <= 1'b0;
          status_r <= END_TERM;
        end
        OP_FINISH: begin
          fin_r    <= 1'b1;
          status_r <= cmd.fin_status;
        end
        OP_PTR_FIRST: begin
          if (!ptr_r) begin
            stop_r <= LEN_W'(cur_ext + (CUR_W + 1)'(2));
            ptr_r  <= 1'b1;
          end
        end
        OP_PTR_JUMP: begin
          cursor_r <= {hi_r, rd_data};
          hop_r    <= hop_r + HOP_W'(1);
        end
        OP_TERM: begin
          if (!ptr_r) begin
            stop_r <= LEN_W'(cur_p1);
          end
          fin_r    <= 1'b1;
          status_r <= END_TERM;
        end
        OP_LABEL_OPEN: begin
          cursor_r <= cur_p1[CUR_W-1:0];
          left_r   <= rd_data;
          dot_r    <= 1'b1;
        end
        OP_CHAR: begin
          cursor_r <= cur_p1[CUR_W-1:0];
          left_r   <= left_r - 8'd1;
        end
        default: begin
        end
      endcase
    end
  end

  // Pending character and pointer high bits.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_PTR_FIRST) begin
      hi_r <= rd_data[5:0] & PTR_HIGH_MASK[5:0];
    end
    if (cmd.op == OP_LABEL_OPEN && dot_r) begin
      char_r <= DOT_CHAR;
    end else if (cmd.op == OP_CHAR) begin
      char_r <= rd_data;
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      if (cmd.emit_last) begin
        out_r.name_char  <= 8'd0;
        out_r.last       <= 1'b1;
        out_r.end_offset <= stop_r;
        out_r.end_status <= status_r;
      end else begin
        out_r.name_char  <= char_r;
        out_r.last       <= 1'b0;
        out_r.end_offset <= '0;
        out_r.end_status <= END_TERM;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

`default_nettype wire

/* sv/dnsd_ctrl.sv */
// Decoder controller: sequences length-byte reads, pointer hops and word emission.
`default_nettype none

module dnsd_ctrl
  import dnsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] mode,
  input  wire sts_t       sts,
  output      logic       in_ready,
  output      cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LEN,
    S_PTR,
    S_CHAR,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   emit_last_r, emit_last_nxt;

  // State and emit-kind registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      emit_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      emit_last_r <= emit_last_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt      = state_r;
    emit_last_nxt  = emit_last_r;
    in_ready       = 1'b0;
    cmd.op         = OP_NONE;
    cmd.fin_status = END_TERM;
    cmd.emit_last  = emit_last_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (mode)
            MODE_LOAD:  cmd.op = OP_LOAD;
            MODE_START: cmd.op = OP_START;
            MODE_PULL: begin
              priority if (sts.finished) begin
                emit_last_nxt = 1'b1;
                state_nxt     = S_EMIT;
              end else if (sts.label_active) begin
                cmd.op    = OP_READ_CUR;
                state_nxt = S_CHAR;
              end else begin
                state_nxt = S_CHECK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CHECK: begin
        priority if (sts.hop_limit) begin
          cmd.op         = OP_FINISH;
          cmd.fin_status = END_HOPS;
          emit_last_nxt  = 1'b1;
          state_nxt      = S_EMIT;
        end else if (sts.cur_past) begin
          cmd.op         = OP_FINISH;
          cmd.fin_status = END_OVERRUN;
          emit_last_nxt  = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          cmd.op    = OP_READ_CUR;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        priority if (sts.is_ptr && sts.ptr_past) begin
          cmd.op         = OP_FINISH;
          cmd.fin_status = END_OVERRUN;
          emit_last_nxt  = 1'b1;
          state_nxt      = S_EMIT;
        end else if (sts.is_ptr) begin
          cmd.op    = OP_PTR_FIRST;
          state_nxt = S_PTR;
        end else if (sts.is_zero) begin
          cmd.op        = OP_TERM;
          emit_last_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end else if (sts.label_past) begin
          cmd.op         = OP_FINISH;
          cmd.fin_status = END_OVERRUN;
          emit_last_nxt  = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          cmd.op = OP_LABEL_OPEN;
          // A label after the first one is announced by its dot alone.
          if (sts.dot_needed) begin
            emit_last_nxt = 1'b0;
            state_nxt     = S_EMIT;
          end else begin
            state_nxt = S_CHAR;
          end
        end
      end
      S_PTR: begin
        cmd.op    = OP_PTR_JUMP;
        state_nxt = S_CHECK;
      end
      S_CHAR: begin
        cmd.op        = OP_CHAR;
        emit_last_nxt = 1'b0;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/dns_name_decompressor_top.sv */
// Top level of the compressed domain name decoder.
//
//   channel | direction | handshake              | word
//   in_     | input     | in_valid / in_ready    | in_word  (in_word_t)
//   out_    | output    | out_valid / out_ready  | out_word (out_word_t)
//
// Load and start words are taken straight from idle. A pull inside a label returns the
// next character and a pull on a finished name returns the final marker. A pull that
// opens a label returns the dot or the first character; a final marker may also be
// found by the walk. Each compression pointer followed adds a pointer step, all paced
// by the single read port of the packet RAM and its registered read data.
// Synchronous reset returns the decoder to the finished state; packet RAM contents
// are undefined until loaded. in_ready is high only while the controller is idle;
// a result waits in the output register while later loads and starts are accepted.
`default_nettype none

module dns_name_decompressor_top
  import dnsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_word_t  in_word,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_word_t out_word
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer for the name walk.
  dnsd_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .mode    (in_word.mode),
    .sts     (sts),
    .in_ready(in_ready),
    .cmd     (cmd)
  );

  // Packet store, walk registers and output word.
  dnsd_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_ready(out_ready),
    .sts      (sts),
    .out_valid(out_valid),
    .out_word (out_word)
  );

endmodule

`default_nettype wire

/* dv/tb_dns_name_decompressor_top.sv */
// Self-checking testbench for the DNS name decompressor: scoreboard, stimulus and result checks.

module tb_dns_name_decompressor_top;
  import dnsd_pkg::*;

  // Mode value that the block must ignore.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Part of the store that is kept fully written; random length bounds stay inside it.
  localparam int WIN = 256;

  // Keeps its own copy of the packet store and name walk, and the expected words.
  class name_walk_scoreboard;
    logic [7:0]  pkt_mem [STORE_DEPTH];
    int unsigned cursor;
    int unsigned label_left;
    int unsigned pkt_limit;
    logic [10:0] stop_at;
    bit          jumped;
    int unsigned hops;
    bit          need_dot;
    bit          walk_done;
    logic [1:0]  walk_status;
    out_word_t   want_q[$];
    int          faults;

    function new();
      foreach (pkt_mem[i]) pkt_mem[i] = 8'h00;
      cursor      = 0;
      label_left  = 0;
      pkt_limit   = 0;
      stop_at     = '0;
      jumped      = 1'b0;
      hops        = 0;
      need_dot    = 1'b0;
      walk_done   = 1'b1;
      walk_status = END_TERM;
      faults      = 0;
    endfunction

    function logic [7:0] mem_at(int unsigned pos);
      if (pos < STORE_DEPTH) return pkt_mem[pos];
      return 8'h00;
    endfunction

    function void close_walk(logic [1:0] status);
      walk_done   = 1'b1;
      walk_status = status;
    endfunction

    // Hands out the next character of the current label.
    function logic [7:0] take_char();
      logic [7:0] ch;
      ch = mem_at(cursor);
      cursor = (cursor + 1) & 32'h7FFF;
      label_left--;
      return ch;
    endfunction

    // Works out the word that one pull produces and advances the walk.
    function out_word_t next_result();
      out_word_t r;
      logic [7:0] lb;
      bit searching;
      r = '0;
      if (!walk_done && label_left != 0) begin
        r.name_char = take_char();
      end else if (!walk_done) begin
        searching = 1'b1;
        while (searching) begin
          searching = 1'b0;
          if (hops >= MAX_HOPS) begin
            close_walk(END_HOPS);
          end else if (cursor >= pkt_limit) begin
            close_walk(END_OVERRUN);
          end else begin
            lb = mem_at(cursor);
            if ((lb & PTR_MARK) == PTR_MARK) begin
              // Compression pointer: the first one fixes where the name ends in place.
              if (cursor + 1 >= pkt_limit) begin
                close_walk(END_OVERRUN);
              end else begin
                if (!jumped) begin
                  stop_at = 11'(cursor + 2);
                  jumped  = 1'b1;
                end
                cursor = (32'(lb & PTR_HIGH_MASK) << 8) | 32'(mem_at(cursor + 1));
                hops++;
                searching = 1'b1;
              end
            end else if (lb == 8'h00) begin
              if (!jumped) stop_at = 11'(cursor + 1);
              close_walk(END_TERM);
            end else if (cursor + 1 + lb > pkt_limit) begin
              close_walk(END_OVERRUN);
            end else begin
              cursor     = cursor + 1;
              label_left = lb;
              if (need_dot) begin
                r.name_char = DOT_CHAR;
              end else begin
                need_dot    = 1'b1;
                r.name_char = take_char();
              end
            end
          end
        end
      end
      if (walk_done) begin
        r.name_char  = 8'h00;
        r.last       = 1'b1;
        r.end_offset = stop_at;
        r.end_status = walk_status;
      end
      return r;
    endfunction

    // Called for every word the block accepts on its input.
    function void note_input(in_word_t w);
      case (w.mode)
        MODE_LOAD: begin
          pkt_mem[w.load_address] = w.load_byte;
        end
        MODE_START: begin
          cursor      = w.start_offset;
          pkt_limit   = (w.packet_length > STORE_DEPTH) ? STORE_DEPTH : w.packet_length;
          stop_at     = 11'(w.start_offset);
          label_left  = 0;
          jumped      = 1'b0;
          hops        = 0;
          need_dot    = 1'b0;
          walk_done   = 1'b0;
          walk_status = END_TERM;
        end
        MODE_PULL: begin
          want_q = {want_q, next_result()};
        end
        default: begin
        end
      endcase
    endfunction

    // Called for every word the block hands over on its output.
    function void check_result(out_word_t got);
      out_word_t want;
      if (want_q.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("ERROR: unexpected word: char %02h last %0d end %0d status %0d",
                   got.name_char, got.last, got.end_offset, got.end_status);
        return;
      end
      want = want_q.pop_front();
      if (got.name_char !== want.name_char || got.last !== want.last ||
          got.end_offset !== want.end_offset || got.end_status !== want.end_status) begin
        faults++;
        if (faults <= 10)
          $display("ERROR: exp char %02h last %0d end %0d status %0d",
                   want.name_char, want.last, want.end_offset, want.end_status,
                   ", got char %02h last %0d end %0d status %0d",
                   got.name_char, got.last, got.end_offset, got.end_status);
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  name_walk_scoreboard sb;
  idle_mode_e          idle_mode;
  bit                  hold_req;
  bit                  hold_done;
  int unsigned         rand_items;
  int unsigned         name_starts[$];
  logic [7:0]          image [WIN];

  dns_name_decompressor_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stalls by phase, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    hold_req  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      if (!rst_n)
        out_ready <= 1'b0;
      else if (idle_mode == IDLE_RECV)
        out_ready <= ($urandom_range(0, 99) >= 47);
      else if (idle_mode == IDLE_BOTH)
        out_ready <= ($urandom_range(0, 99) >= 20);
      else
        out_ready <= 1'b1;
    end
  end

  // Every word handed over is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_word);
  end

  function automatic in_word_t mk_word(logic [1:0] m);
    in_word_t w;
    w.mode          = m;
    w.load_address  = 10'($urandom_range(0, 1023));
    w.load_byte     = 8'($urandom_range(0, 255));
    w.start_offset  = 10'($urandom_range(0, 1023));
    w.packet_length = 11'($urandom_range(0, 2047));
    return w;
  endfunction

  // Offers one word, with random gaps in front by phase, and waits for the handshake.
  task automatic send(in_word_t w);
    while ((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 47) ||
           (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 20)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    if (w.mode != MODE_UNUSED) rand_items++;
  endtask

  task automatic put_byte(int unsigned addr, int unsigned val);
    in_word_t w;
    w = mk_word(MODE_LOAD);
    w.load_address = 10'(addr);
    w.load_byte    = 8'(val);
    send(w);
  endtask

  task automatic start_walk(int unsigned off, int unsigned len);
    in_word_t w;
    w = mk_word(MODE_START);
    w.start_offset  = 10'(off);
    w.packet_length = 11'(len);
    send(w);
  endtask

  task automatic pull_one();
    send(mk_word(MODE_PULL));
  endtask

  // Holds the input quiet until every expected word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Pulls until the final marker, with an occasional store write or ignored word mixed in.
  task automatic pull_to_end();
    for (int k = 0; k < 400 && !sb.walk_done; k++) begin
      if ($urandom_range(0, 24) == 0)
        put_byte($urandom_range(0, 1023), $urandom_range(0, 255));
      else if ($urandom_range(0, 49) == 0)
        send(mk_word(MODE_UNUSED));
      pull_one();
    end
    repeat ($urandom_range(0, 2)) pull_one();
  endtask

  // Writes a well-formed name with random labels, ending in a terminator or a pointer,
  // then decodes it under a random length bound inside the written window.
  task automatic name_episode();
    int unsigned base, p, nl, len, tgt, plen, kind;
    base = $urandom_range(0, WIN - 16);
    p    = base;
    nl   = $urandom_range(1, 4);
    for (int l = 0; l < nl; l++) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      if (p + len + 3 > WIN - 1) break;
      put_byte(p, len);
      for (int i = 1; i <= len; i++) put_byte(p + i, $urandom_range(0, 255));
      p += len + 1;
    end
    kind = $urandom_range(0, 9);
    if (kind < 5 || p > WIN - 3) begin
      put_byte(p, 0);
      p++;
    end else begin
      // Pointer back to an earlier name, to anywhere, or to itself for the hop limit.
      if (kind == 9)
        tgt = p;
      else if (kind == 8)
        tgt = $urandom_range(0, 16383);
      else if (name_starts.size() != 0)
        tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
      else
        tgt = 0;
      put_byte(p, 8'hC0 | ((tgt >> 8) & 8'h3F));
      put_byte(p + 1, tgt & 8'hFF);
      p += 2;
    end
    kind = $urandom_range(0, 9);
    if (kind < 4)
      plen = WIN;
    else if (kind < 6)
      plen = $urandom_range(p, WIN);
    else if (kind < 8)
      plen = p;
    else
      plen = $urandom_range(base, p);
    start_walk(base, plen);
    pull_to_end();
    name_starts = {name_starts, base};
    if (name_starts.size() > 16) void'(name_starts.pop_front());
  endtask

  // Random bytes, random bounds and pulls with or without a fresh start.
  task automatic noise_episode();
    int unsigned b;
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0: b = $urandom_range(8'h40, 8'hBF);
        1: b = $urandom_range(8'hC0, 8'hFF);
        default: b = $urandom_range(0, 255);
      endcase
      put_byte($urandom_range(0, 1023), b);
    end
    if ($urandom_range(0, 4) != 0)
      start_walk($urandom_range(0, 1023), $urandom_range(0, WIN));
    repeat ($urandom_range(1, 6)) pull_one();
  endtask

  initial begin
    idle_mode_e want_mode;
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    idle_mode = IDLE_NONE;
    hold_done = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pull straight after reset repeats the idle marker; mode 3 is ignored.
    pull_one();
    send(mk_word(MODE_UNUSED));

    // Fill the window so no walk can reach an unwritten entry.
    foreach (image[i]) image[i] = 8'($urandom_range(0, 255));
    image[0]  = 8'h00;                      // empty name
    image[1]  = 8'h01;                      // one-byte label, then pointer to offset 10
    image[2]  = 8'hFF;
    image[3]  = 8'hC0;
    image[4]  = 8'd10;
    image[10] = 8'h01;
    image[11] = 8'h00;
    image[12] = 8'h00;
    image[20] = 8'hC0;                      // pointer to itself
    image[21] = 8'd20;
    image[30] = 8'h80;                      // plain length in the reserved range
    image[40] = 8'hC3;                      // pointer cut off by the length bound
    foreach (image[i]) put_byte(i, image[i]);

    // Directed cases, with gaps on both sides.
    idle_mode = IDLE_BOTH;
    start_walk(0, 16);
    pull_one();
    start_walk(1, 2047);                    // oversized length, pointer, dot between labels
    repeat (5) pull_one();
    start_walk(20, STORE_DEPTH);            // hop limit
    pull_one();
    start_walk(30, 100);                    // label overruns the packet
    pull_one();
    start_walk(40, 41);                     // second pointer byte past the length
    pull_one();
    start_walk(1023, 0);                    // start past the length
    pull_one();
    drain_results();

    // Random part, cycling through the idling phases with a full drain in between.
    rand_items = 0;
    while (rand_items < 840) begin
      want_mode = idle_mode_e'((rand_items / 120) % 4);
      if (want_mode != idle_mode) begin
        drain_results();
        idle_mode = want_mode;
      end
      if (!hold_done && idle_mode == IDLE_NONE && rand_items >= 400) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 3) != 0)
        name_episode();
      else
        noise_episode();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (40) @(posedge clk);
    if (sb.faults == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
sv/dnsd_pkg.sv
sv/dnsd_ram.sv
sv/dnsd_datapath.sv
sv/dnsd_ctrl.sv
sv/dns_name_decompressor_top.sv
dv/tb_dns_name_decompressor_top.sv
